// ===== hw/rtl/mersenne_twister_generator_core_macros.svh =====
// Assertion macros shared by the checker files of the generator core.
`ifndef MERSENNE_TWISTER_GENERATOR_CORE_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_CORE_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define MTG_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("generator core check failed");

// The condition must hold in the cycle after the trigger.
`define MTG_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("generator core check failed");

`endif

// ===== hw/rtl/mtg_pkg.sv =====
// Types and constants shared by the generator core modules.
`timescale 1ns / 1ps

package mtg_pkg;

  localparam int MTG_WORD_W       = 32;
  localparam int MTG_STATE_WORDS  = 624;
  localparam int MTG_TWIST_OFFSET = 397;

  localparam logic [31:0] MTG_SEED_RESET   = 32'd5489;
  localparam logic [31:0] MTG_SEED_MULT    = 32'd1812433253;
  localparam logic [31:0] MTG_UPPER_BIT    = 32'h8000_0000;
  localparam logic [31:0] MTG_LOWER_BITS   = 32'h7fff_ffff;
  localparam logic [31:0] MTG_TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [31:0] MTG_TEMPER_B     = 32'h9d2c_5680;
  localparam logic [31:0] MTG_TEMPER_C     = 32'hefc6_0000;

  localparam logic MTG_OP_RAW    = 1'b0;
  localparam logic MTG_OP_RANGED = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [31:0] range_low;
    logic [31:0] range_high;
  } mtg_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        range_error;
  } mtg_rsp_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } mtg_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] remainder;
  } mtg_div_rsp_t;

endpackage

// ===== hw/rtl/mersenne_twister_generator_core.sv =====
// MT19937 generator core with raw and range-reduced draws.
`timescale 1ns / 1ps

// MT19937 random word generator. The 624-word state sits in a two-read, one-write
// memory; a sequencer seeds it, twists it and reads one word per draw. After
// reset, and after every write of the seed register, the table is refilled
// from the seed: the seed itself is the first word, and each of the other
// 623 takes a multiply, then the add and write; no request transfer is taken
// during the refill. A raw draw reads the state word, tempers it, then goes
// through the finish step into the output register. A ranged draw adds the
// remainder unit, which works one bit per cycle; a zero span skips it,
// returns 0 and flags range_error. Every 624th draw (the first one after a
// refill as well) is preceded by a twist of the whole table: a read of word 0
// primes it, then each word is read and written in turn. The result sits in an
// output register, so the next request may be taken while a result still waits.
module mersenne_twister_generator_core
  import mtg_pkg::*;
#(
  parameter int STATE_WORDS  = MTG_STATE_WORDS,
  parameter int TWIST_OFFSET = MTG_TWIST_OFFSET
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic     req_valid,
  output logic     req_stall,
  input  mtg_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output mtg_rsp_t rsp
);

  localparam int AW = $clog2(STATE_WORDS);
  localparam logic [AW-1:0] LAST_IDX = AW'(STATE_WORDS - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL_START,
    ST_FILL_MUL,
    ST_FILL_WR,
    ST_TW_LOAD,
    ST_TW_CAP,
    ST_TW_RD,
    ST_TW_WR,
    ST_DRAW_RD,
    ST_DRAW_TEMPER,
    ST_DIV_RUN,
    ST_FINISH
  } state_t;

  state_t        state;
  logic [31:0]   seed;
  logic [AW-1:0] idx;
  logic [AW-1:0] k;
  logic [31:0]   prev;
  logic [31:0]   prod;
  logic [31:0]   cur;
  mtg_req_t      req_q;
  mtg_rsp_t      res;
  logic          div_start;
  logic [31:0]   div_dividend;
  logic [31:0]   div_divisor;

  // Memory ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr_a;
  logic [AW-1:0] ram_raddr_b;
  logic [31:0]   ram_rdata_a;
  logic [31:0]   ram_rdata_b;

  mtg_div_req_t  div_req;
  mtg_div_rsp_t  div_rsp;

  logic [31:0]   mix;
  logic [31:0]   fill_word;
  logic [AW-1:0] nxt_addr;
  logic [AW:0]   far_sum;
  logic [AW-1:0] far_addr;
  logic [31:0]   twist_y;
  logic [31:0]   twist_word;
  logic [31:0]   tempered;
  logic [31:0]   span;

  // Output tempering of one state word.
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & MTG_TEMPER_B);
    y = y ^ ((y << 15) & MTG_TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  mtg_state_ram #(
    .DEPTH (STATE_WORDS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .rdata_a (ram_rdata_a),
    .raddr_b (ram_raddr_b),
    .rdata_b (ram_rdata_b)
  );

  assign div_req.start    = div_start;
  assign div_req.dividend = div_dividend;
  assign div_req.divisor  = div_divisor;

  mtg_mod_unit u_mod (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Seeding recurrence: the multiply is registered, the index is added after.
  assign mix       = prev ^ (prev >> 30);
  assign fill_word = prod + 32'(k);

  // Twist neighbors of word k: the next word and the word TWIST_OFFSET ahead,
  // both wrapping around the table.
  assign nxt_addr = (k == LAST_IDX) ? '0 : k + AW'(1);
  assign far_sum  = {1'b0, k} + (AW + 1)'(TWIST_OFFSET);
  assign far_addr = (far_sum >= (AW + 1)'(STATE_WORDS)) ?
                    AW'(far_sum - (AW + 1)'(STATE_WORDS)) : far_sum[AW-1:0];

  // Word k's top bit joins the low bits of the next word. The next word may
  // already be twisted (word 0 when k is the last), as the in-place update
  // requires.
  assign twist_y    = (cur & MTG_UPPER_BIT) | (ram_rdata_a & MTG_LOWER_BITS);
  assign twist_word = ram_rdata_b ^ (twist_y >> 1) ^
                      (twist_y[0] ? MTG_TWIST_MATRIX : 32'd0);

  assign tempered = temper(ram_rdata_a);
  assign span     = req_q.range_high - req_q.range_low;

  // Memory access for the current step. Reads are only issued in steps
  // that do not write, so an entry is never read in the cycle it is written.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = k;
    ram_wdata   = fill_word;
    ram_raddr_a = '0;
    ram_raddr_b = '0;
    case (state)
      ST_FILL_START: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = seed;
      end
      ST_FILL_WR: begin
        ram_we = 1'b1;
      end
      ST_TW_LOAD: begin
        ram_raddr_a = '0;
      end
      ST_TW_RD: begin
        ram_raddr_a = nxt_addr;
        ram_raddr_b = far_addr;
      end
      ST_TW_WR: begin
        ram_we    = 1'b1;
        ram_wdata = twist_word;
      end
      ST_DRAW_RD: begin
        ram_raddr_a = idx;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Requests are taken only when the sequencer is waiting for work.
  assign req_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL_START;
      seed      <= MTG_SEED_RESET;
      idx       <= '0;
      k         <= '0;
      rsp_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      // Output register: a finished result enters once the register is free
      // or its current result is leaving; otherwise a taken result empties it.
      if ((state == ST_FINISH) && (!rsp_valid || !rsp_stall)) begin
        rsp       <= res;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (cfg_we) begin
        // A seed write restarts the refill from the new value.
        seed      <= cfg_wdata;
        idx       <= '0;
        div_start <= 1'b0;
        state     <= ST_FILL_START;
      end else begin
        case (state)
          ST_IDLE: begin
            if (req_valid) begin
              req_q <= req;
              state <= (idx == '0) ? ST_TW_LOAD : ST_DRAW_RD;
            end
          end
          ST_FILL_START: begin
            prev  <= seed;
            k     <= AW'(1);
            state <= ST_FILL_MUL;
          end
          ST_FILL_MUL: begin
            prod  <= MTG_SEED_MULT * mix;
            state <= ST_FILL_WR;
          end
          ST_FILL_WR: begin
            prev <= fill_word;
            if (k == LAST_IDX) begin
              idx   <= '0;
              state <= ST_IDLE;
            end else begin
              k     <= k + AW'(1);
              state <= ST_FILL_MUL;
            end
          end
          ST_TW_LOAD: begin
            state <= ST_TW_CAP;
          end
          ST_TW_CAP: begin
            cur   <= ram_rdata_a;
            k     <= '0;
            state <= ST_TW_RD;
          end
          ST_TW_RD: begin
            state <= ST_TW_WR;
          end
          ST_TW_WR: begin
            // The next word read here is the original word k+1, the current
            // word of the following step.
            cur <= ram_rdata_a;
            if (k == LAST_IDX) begin
              state <= ST_DRAW_RD;
            end else begin
              k     <= k + AW'(1);
              state <= ST_TW_RD;
            end
          end
          ST_DRAW_RD: begin
            state <= ST_DRAW_TEMPER;
          end
          ST_DRAW_TEMPER: begin
            idx <= (idx == LAST_IDX) ? '0 : idx + AW'(1);
            if (req_q.opcode == MTG_OP_RAW) begin
              res.value       <= tempered;
              res.range_error <= 1'b0;
              state           <= ST_FINISH;
            end else if (span == 32'd0) begin
              res.value       <= 32'd0;
              res.range_error <= 1'b1;
              state           <= ST_FINISH;
            end else begin
              div_start    <= 1'b1;
              div_dividend <= tempered;
              div_divisor  <= span;
              state        <= ST_DIV_RUN;
            end
          end
          ST_DIV_RUN: begin
            // The start pulse lasts one cycle.
            div_start <= 1'b0;
            if (div_rsp.done) begin
              res.value       <= div_rsp.remainder + req_q.range_low;
              res.range_error <= 1'b0;
              state           <= ST_FINISH;
            end
          end
          ST_FINISH: begin
            // The result moves to the output register in this cycle once it
            // is free.
            if (!rsp_valid || !rsp_stall) begin
              state <= ST_IDLE;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/mtg_state_ram.sv =====
// State table memory: one write port and two registered read ports.
`timescale 1ns / 1ps

module mtg_state_ram
  import mtg_pkg::*;
#(
  parameter int DEPTH = MTG_STATE_WORDS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [MTG_WORD_W-1:0] wdata,
  input  logic [AW-1:0]         raddr_a,
  output logic [MTG_WORD_W-1:0] rdata_a,
  input  logic [AW-1:0]         raddr_b,
  output logic [MTG_WORD_W-1:0] rdata_b
);

  logic [MTG_WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hw/rtl/mtg_mod_unit.sv =====
// Restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps

module mtg_mod_unit
  import mtg_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  mtg_div_req_t req,
  output mtg_div_rsp_t rsp
);

  localparam int CW = $clog2(MTG_WORD_W + 1);

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [MTG_WORD_W-1:0] rem;
  logic [MTG_WORD_W-1:0] dvd;
  logic [MTG_WORD_W-1:0] dsr;
  logic                  done;
  logic [MTG_WORD_W:0]   trial;
  logic [MTG_WORD_W:0]   rem_next;

  // Shift in the next dividend bit and subtract when the divisor fits.
  always_comb begin
    trial = {rem, dvd[MTG_WORD_W-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = trial - {1'b0, dsr};
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // Done pulses for one cycle after the last quotient bit.
      done <= busy && !req.start && (cnt == CW'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(MTG_WORD_W);
        rem  <= '0;
        dvd  <= req.dividend;
        dsr  <= req.divisor;
      end else if (busy) begin
        rem <= rem_next[MTG_WORD_W-1:0];
        dvd <= {dvd[MTG_WORD_W-2:0], 1'b0};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

// ===== hw/rtl/mtg_checker.sv =====
// Port-level checks for the generator core, bound to the top level.
`timescale 1ns / 1ps
`include "mersenne_twister_generator_core_macros.svh"

module mtg_checker
  import mtg_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     cfg_we,
  input logic     req_valid,
  input logic     req_stall,
  input mtg_req_t req,
  input logic     rsp_valid,
  input logic     rsp_stall,
  input mtg_rsp_t rsp
);

  logic req_xfer;

  assign req_xfer = req_valid && !req_stall;

  // A result offered but not taken stays offered and unchanged.
  `MTG_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

  // One request at a time: a request transfer is followed by a busy cycle.
  `MTG_ASSERT_NEXT(a_req_busy, req_xfer, req_stall)

  // A seed write starts a refill, during which no request is taken.
  `MTG_ASSERT_NEXT(a_cfg_refill, cfg_we, req_stall)

  // A range error always comes with a zero value.
  `MTG_ASSERT_SAME(a_err_zero, rsp_valid && rsp.range_error, rsp.value == 32'd0)

endmodule

bind mersenne_twister_generator_core mtg_checker u_mtg_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_we    (cfg_we),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ===== verif/mersenne_twister_generator_core_test.sv =====
// Self-checking testbench for the MT19937 generator core with raw and ranged draws.
`timescale 1ns / 1ps

module mersenne_twister_generator_core_test;
  import mtg_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 40;
  // The limit covers the seeding passes, the full twists and the ranged
  // draws. Even with every stall at its longest, the run finishes well inside
  // this limit.
  localparam int LIMIT_NS     = 5_000_000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        req_valid = 1'b0;
  logic        req_stall;
  mtg_req_t    req       = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  mtg_rsp_t    rsp;

  mersenne_twister_generator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Draw requests waiting to be presented, and the responses that the
  // accepted requests are expected to produce, oldest first.
  mtg_req_t draw_queue [$];
  mtg_rsp_t rsp_due [$];
  mtg_rsp_t rsp_want;

  int errors       = 0;
  int raw_draws    = 0;
  int ranged_draws = 0;
  int zero_spans   = 0;
  int seed_writes  = 0;
  int checked      = 0;

  // Private copy of the generator: the 624-word state and the position of
  // the next word to be tempered.
  logic [31:0] mt_state [MTG_STATE_WORDS];
  int unsigned mt_pos;

  // Standard MT19937 seeding recurrence, modulo 2^32.
  function automatic void reseed_state(input logic [31:0] s);
    logic [31:0] prev;
    mt_state[0] = s;
    for (int k = 1; k < MTG_STATE_WORDS; k++) begin
      prev = mt_state[k-1];
      mt_state[k] = MTG_SEED_MULT * (prev ^ (prev >> 30)) + 32'(k);
    end
    mt_pos = 0;
  endfunction

  // In-place twist of the whole state. All shifts are logical.
  function automatic void twist_state();
    logic [31:0] y;
    logic [31:0] w;
    for (int k = 0; k < MTG_STATE_WORDS; k++) begin
      y = (mt_state[k] & MTG_UPPER_BIT) |
          (mt_state[(k + 1) % MTG_STATE_WORDS] & MTG_LOWER_BITS);
      w = mt_state[(k + MTG_TWIST_OFFSET) % MTG_STATE_WORDS] ^ (y >> 1);
      if (y[0]) begin
        w = w ^ MTG_TWIST_MATRIX;
      end
      mt_state[k] = w;
    end
  endfunction

  // Takes the next word. The state is twisted first whenever the position is
  // back at zero, so the first draw after seeding also twists.
  function automatic logic [31:0] temper_next();
    logic [31:0] y;
    if (mt_pos == 0) begin
      twist_state();
    end
    y = mt_state[mt_pos];
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & MTG_TEMPER_B);
    y = y ^ ((y << 15) & MTG_TEMPER_C);
    y = y ^ (y >> 18);
    mt_pos = (mt_pos + 1) % MTG_STATE_WORDS;
    return y;
  endfunction

  // Response to one request. A zero span still consumes a word, so the
  // sequence advances even though the value is forced to 0.
  function automatic mtg_rsp_t expected_response(input mtg_req_t r);
    logic [31:0] word;
    logic [31:0] span;
    mtg_rsp_t    e;
    word          = temper_next();
    e.value       = word;
    e.range_error = 1'b0;
    if (r.opcode == MTG_OP_RANGED) begin
      ranged_draws++;
      span = r.range_high - r.range_low;
      if (span == '0) begin
        e.value       = '0;
        e.range_error = 1'b1;
        zero_spans++;
      end else begin
        e.value = (word % span) + r.range_low;
      end
    end else begin
      raw_draws++;
    end
    return e;
  endfunction

  // Request driver. After each transfer it may wait at random before the next
  // request. Now and then it switches into a burst in which it does not wait
  // at all, so requests also get presented without a gap. A stalled request is
  // held unchanged until its transfer takes place.
  int   req_gap   = 0;
  logic req_burst = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        rsp_due.push_back(expected_response(req));
        if ($urandom_range(0, 15) == 0) begin
          req_burst = !req_burst;
        end
        req_gap = req_burst ? 0 : $urandom_range(0, 4);
      end
      if (!req_valid || !req_stall) begin
        if (req_gap > 0) begin
          req_gap--;
          req_valid <= 1'b0;
        end else if (draw_queue.size() != 0) begin
          req       <= draw_queue.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor. It checks every transfer against the oldest expected
  // response, field by field. After each transfer it may stall at random, and
  // it also has burst stretches in which it never stalls.
  int   rsp_hold  = 0;
  logic rsp_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (rsp_due.size() == 0) begin
          $error("response with nothing expected: value %h range_error %b",
                 rsp.value, rsp.range_error);
          errors++;
        end else begin
          rsp_want = rsp_due.pop_front();
          if (rsp.value !== rsp_want.value) begin
            $error("value: expected %h, got %h", rsp_want.value, rsp.value);
            errors++;
          end
          if (rsp.range_error !== rsp_want.range_error) begin
            $error("range_error: expected %b, got %b",
                   rsp_want.range_error, rsp.range_error);
            errors++;
          end
        end
        checked++;
        if ($urandom_range(0, 15) == 0) begin
          rsp_burst = !rsp_burst;
        end
        rsp_hold = rsp_burst ? 0 : $urandom_range(0, 4);
      end
      if (rsp_hold > 0) begin
        rsp_stall <= 1'b1;
        rsp_hold--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic push_draw(input logic op, input logic [31:0] lo, input logic [31:0] hi);
    mtg_req_t item;
    item.opcode     = op;
    item.range_low  = lo;
    item.range_high = hi;
    draw_queue.push_back(item);
  endtask

  // Random requests. Raw and ranged draws are mixed. The ranged ones favor
  // zero spans, tiny spans and spans with the top bit set, alongside fully
  // random bounds that often wrap.
  task automatic queue_random(input int count);
    int          pick;
    logic [31:0] lo;
    logic [31:0] hi;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      lo   = $urandom;
      hi   = $urandom;
      if (pick < 40) begin
        push_draw(MTG_OP_RAW, lo, hi);
      end else if (pick < 50) begin
        push_draw(MTG_OP_RANGED, lo, lo);
      end else if (pick < 65) begin
        push_draw(MTG_OP_RANGED, lo, lo + $urandom_range(1, 16));
      end else if (pick < 75) begin
        push_draw(MTG_OP_RANGED, lo, lo + (hi | MTG_UPPER_BIT));
      end else begin
        push_draw(MTG_OP_RANGED, lo, hi);
      end
    end
  endtask

  // Waits until everything queued has been sent and every expected response
  // has arrived. The state is sampled on the falling edge, when nothing is
  // changing.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (draw_queue.size() != 0 || req_valid || rsp_due.size() != 0);
  endtask

  // A seed write restarts the seeding pass in the block. The block stalls
  // requests until that pass is done, so no extra wait is needed here.
  task automatic write_seed(input logic [31:0] s);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    reseed_state(s);
    seed_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    reseed_state(MTG_SEED_RESET);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run with the reset seed. It covers both operations, a
    // zero span at both extremes, spans of 1, 2, a power of two and the
    // largest one, bounds that wrap, and a raw draw with ignored bounds set
    // to all ones.
    push_draw(MTG_OP_RAW,    32'h0000_0000, 32'h0000_0000);
    push_draw(MTG_OP_RAW,    32'hffff_ffff, 32'hffff_ffff);
    push_draw(MTG_OP_RANGED, 32'h0000_0000, 32'h0000_0000);
    push_draw(MTG_OP_RANGED, 32'hffff_ffff, 32'hffff_ffff);
    push_draw(MTG_OP_RANGED, 32'h0000_0000, 32'h0000_0001);
    push_draw(MTG_OP_RANGED, 32'h0000_0000, 32'hffff_ffff);
    push_draw(MTG_OP_RANGED, 32'hffff_ffff, 32'h0000_0000);
    push_draw(MTG_OP_RANGED, 32'h0000_0001, 32'h0000_0000);
    push_draw(MTG_OP_RANGED, 32'h8000_0000, 32'h7fff_ffff);
    push_draw(MTG_OP_RANGED, 32'hffff_fff0, 32'h0000_0010);
    push_draw(MTG_OP_RANGED, 32'h0000_0005, 32'h0000_0007);
    push_draw(MTG_OP_RANGED, 32'h1234_0000, 32'h1235_0000);
    push_draw(MTG_OP_RANGED, 32'h0000_0000, 32'h8000_0000);
    push_draw(MTG_OP_RANGED, 32'h5a5a_5a5a, 32'h5a5a_5a5a);
    push_draw(MTG_OP_RAW,    32'h5555_5555, 32'haaaa_aaaa);
    push_draw(MTG_OP_RANGED, 32'hffff_fffe, 32'hffff_ffff);

    // The rest of the first phase goes past 624 draws, so a second full
    // twist happens in the middle of the traffic.
    queue_random(650);
    wait_idle();

    // Further phases with other seeds, including both extremes. The pause
    // before each seed write also lets every outstanding response drain.
    write_seed(32'h0000_0000);
    queue_random(60);
    wait_idle();
    write_seed(32'hffff_ffff);
    queue_random(60);
    wait_idle();
    write_seed($urandom);
    queue_random(100);
    wait_idle();
    write_seed(MTG_SEED_RESET);
    queue_random(30);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rsp_due.size() != 0) begin
      $error("%0d expected responses never arrived", rsp_due.size());
      errors++;
    end

    $display("Ran %0d raw and %0d ranged draws (%0d of them with a zero span) under %0d seed writes.",
             raw_draws, ranged_draws, zero_spans, seed_writes);
    $display("Checked %0d responses; %0d errors.", checked, errors);
    if (errors == 0) begin
      $display("mersenne_twister_generator_core: match");
    end else begin
      $display("mersenne_twister_generator_core: mismatch");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("mersenne_twister_generator_core: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mtg_pkg.sv
hw/rtl/mtg_state_ram.sv
hw/rtl/mtg_mod_unit.sv
hw/rtl/mersenne_twister_generator_core.sv
hw/rtl/mtg_checker.sv
verif/mersenne_twister_generator_core_test.sv
